FILE: rtl/lew_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types of the line editor.
package lew_pkg;

	localparam int LINE_WIDTH_DEF = 40;
	localparam int CNT_W          = 6;

	localparam logic [7:0] CH_EOT    = 8'd4;
	localparam logic [7:0] CH_BS     = 8'd8;
	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_KILL   = 8'd21;
	localparam logic [7:0] CH_WERASE = 8'd23;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_BANG   = 8'd33;
	localparam logic [7:0] CH_TILDE  = 8'd126;
	localparam logic [7:0] CH_DEL    = 8'd127;

	typedef enum logic [2:0] {
		ACT_ECHO    = 3'd0,
		ACT_BELL    = 3'd1,
		ACT_RUBOUT  = 3'd2,
		ACT_NEWLINE = 3'd3,
		ACT_END     = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		CLS_EOT,
		CLS_ERASE,
		CLS_KILL,
		CLS_WERASE,
		CLS_SPACE,
		CLS_PRINT,
		CLS_OTHER
	} byte_class_t;

	typedef enum logic [1:0] {K_HOLD, K_FILL, K_DEC, K_INC} k_op_t;

	typedef enum logic [2:0] {F_HOLD, F_CLR, F_DEC, F_INC, F_K, F_WLEN} fill_op_t;

	typedef enum logic [1:0] {CHS_ZERO, CHS_BYTE, CHS_RDATA} char_sel_t;

	typedef enum logic [2:0] {CNT_ZERO, CNT_ONE, CNT_FILL, CNT_FILL_K, CNT_WLEN} cnt_sel_t;

	typedef struct packed {
		logic        cap_byte;
		k_op_t       k_op;
		logic        j_clr;
		logic        j_inc;
		logic        wlen_load;
		fill_op_t    fill_op;
		logic        wr_en;
		logic        wr_copy;
		logic        emit;
		action_t     act;
		char_sel_t   char_sel;
		cnt_sel_t    cnt_sel;
		logic        last;
	} cmd_t;

	typedef struct packed {
		byte_class_t cls;
		logic        fill_zero;
		logic        fill_full;
		logic        k_zero;
		logic        fill_eq_k;
		logic        rd_blank;
		logic        j_done;
		logic        out_free;
	} status_t;

endpackage

FILE: rtl/line_editor_word_wrap.sv
`timescale 1ns / 1ps
// Top level of the line editor with word wrap: controller, datapath and checks.
//
// The input channel carries one keyboard byte per word (in_valid, in_stall, in_byte).
// The output channel carries terminal actions, one per word: echo, bell, rubout,
// newline or end of input, with last set on the final word caused by a byte.
// A byte may cause no output word at all (for example an erase on an empty line).
//
// The block works on one byte at a time; in_stall is high from the cycle after a
// byte is taken until its last output word has been loaded into the output register.
// A control byte with a single result loads its word from the dispatch state, and a
// stored character from the put state that follows it; the block then returns to
// idle, where the next byte can be taken. Word erase walks the line backward one
// entry per cycle through the line memory, first over blanks and then over the
// word, and then loads its rubout word. A wrap scans back for the last blank and
// then rubs the word out, starts a new line and moves the word to the line start,
// one echo word per character, before it stores the new byte.
//
// Reset empties the line and drops any pending output word. While out_stall is
// high the output word holds and the block waits before it loads another word;
// it still takes a new byte when its only remaining work is the word sitting in
// the output register.
module line_editor_word_wrap #(
	parameter int LINE_WIDTH = lew_pkg::LINE_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                in_byte,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                action,
	output logic [7:0]                out_char,
	output logic [lew_pkg::CNT_W-1:0] rubout_count,
	output logic                      last
);
	import lew_pkg::*;

	cmd_t    cmd;
	status_t st;

	// The controller owns sequencing; it never touches data.
	lew_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// The datapath holds the line memory, the fill count, scan pointers and the
	// output register that decouples the two channels.
	lew_datapath #(
		.LINE_WIDTH (LINE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_byte      (in_byte),
		.cmd          (cmd),
		.st           (st),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.action       (action),
		.out_char     (out_char),
		.rubout_count (rubout_count),
		.last         (last)
	);

	// A new output word is only produced when the output register can take it.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("output word produced while the output register was occupied");

	// Once a byte is taken, the block is busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after a byte was taken");

	// A rubout word always erases at least one character.
	a_rubout_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (action == ACT_RUBOUT)) |-> (rubout_count != '0))
		else $error("rubout word with a zero count");

endmodule

FILE: rtl/lew_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the line editor: sequences scans, copies and result words.
module lew_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  lew_pkg::status_t st,
	output lew_pkg::cmd_t  cmd
);
	import lew_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_WE_BLANK,
		S_WE_WORD,
		S_WE_DONE,
		S_WR_SCAN,
		S_WR_RUB,
		S_WR_NL,
		S_WR_COPY,
		S_PUT
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd.cap_byte = 1'b0;
		cmd.k_op     = K_HOLD;
		cmd.j_clr    = 1'b0;
		cmd.j_inc    = 1'b0;
		cmd.wlen_load = 1'b0;
		cmd.fill_op  = F_HOLD;
		cmd.wr_en    = 1'b0;
		cmd.wr_copy  = 1'b0;
		cmd.emit     = 1'b0;
		cmd.act      = ACT_ECHO;
		cmd.char_sel = CHS_ZERO;
		cmd.cnt_sel  = CNT_ZERO;
		cmd.last     = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap_byte = 1'b1;
					state_d      = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (st.cls)
					CLS_EOT: begin
						if (st.out_free) begin
							cmd.emit = 1'b1;
							cmd.act  = st.fill_zero ? ACT_END : ACT_BELL;
							cmd.last = 1'b1;
							state_d  = S_IDLE;
						end
					end
					CLS_ERASE: begin
						if (st.fill_zero) begin
							state_d = S_IDLE;
						end else if (st.out_free) begin
							cmd.emit    = 1'b1;
							cmd.act     = ACT_RUBOUT;
							cmd.cnt_sel = CNT_ONE;
							cmd.last    = 1'b1;
							cmd.fill_op = F_DEC;
							state_d     = S_IDLE;
						end
					end
					CLS_KILL: begin
						if (st.fill_zero) begin
							state_d = S_IDLE;
						end else if (st.out_free) begin
							cmd.emit    = 1'b1;
							cmd.act     = ACT_RUBOUT;
							cmd.cnt_sel = CNT_FILL;
							cmd.last    = 1'b1;
							cmd.fill_op = F_CLR;
							state_d     = S_IDLE;
						end
					end
					CLS_WERASE: begin
						cmd.k_op = K_FILL;
						state_d  = S_WE_BLANK;
					end
					CLS_SPACE: begin
						state_d = st.fill_full ? S_IDLE : S_PUT;
					end
					CLS_PRINT: begin
						if (st.fill_full) begin
							cmd.k_op = K_FILL;
							state_d  = S_WR_SCAN;
						end else begin
							state_d = S_PUT;
						end
					end
					CLS_OTHER: begin
						if (st.out_free) begin
							cmd.emit = 1'b1;
							cmd.act  = ACT_BELL;
							cmd.last = 1'b1;
							state_d  = S_IDLE;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_WE_BLANK: begin
				if (st.k_zero) begin
					state_d = S_WE_DONE;
				end else if (st.rd_blank) begin
					cmd.k_op = K_DEC;
				end else begin
					state_d = S_WE_WORD;
				end
			end
			S_WE_WORD: begin
				if (st.k_zero || st.rd_blank) begin
					state_d = S_WE_DONE;
				end else begin
					cmd.k_op = K_DEC;
				end
			end
			S_WE_DONE: begin
				if (st.fill_eq_k) begin
					state_d = S_IDLE;
				end else if (st.out_free) begin
					cmd.emit    = 1'b1;
					cmd.act     = ACT_RUBOUT;
					cmd.cnt_sel = CNT_FILL_K;
					cmd.last    = 1'b1;
					cmd.fill_op = F_K;
					state_d     = S_IDLE;
				end
			end
			S_WR_SCAN: begin
				if (st.k_zero) begin
					state_d = S_IDLE;
				end else if (st.rd_blank) begin
					cmd.wlen_load = 1'b1;
					cmd.j_clr     = 1'b1;
					cmd.k_op      = K_INC;
					state_d       = st.fill_eq_k ? S_WR_NL : S_WR_RUB;
				end else begin
					cmd.k_op = K_DEC;
				end
			end
			S_WR_RUB: begin
				if (st.out_free) begin
					cmd.emit    = 1'b1;
					cmd.act     = ACT_RUBOUT;
					cmd.cnt_sel = CNT_WLEN;
					state_d     = S_WR_NL;
				end
			end
			S_WR_NL: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.act  = ACT_NEWLINE;
					state_d  = S_WR_COPY;
				end
			end
			S_WR_COPY: begin
				if (st.j_done) begin
					cmd.fill_op = F_WLEN;
					state_d     = S_PUT;
				end else if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.act      = ACT_ECHO;
					cmd.char_sel = CHS_RDATA;
					cmd.wr_en    = 1'b1;
					cmd.wr_copy  = 1'b1;
					cmd.j_inc    = 1'b1;
					cmd.k_op     = K_INC;
				end
			end
			S_PUT: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.act      = ACT_ECHO;
					cmd.char_sel = CHS_BYTE;
					cmd.last     = 1'b1;
					cmd.wr_en    = 1'b1;
					cmd.fill_op  = F_INC;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/lew_datapath.sv
`timescale 1ns / 1ps
// Datapath of the line editor: line memory, fill count, scan pointers and output register.
module lew_datapath #(
	parameter int LINE_WIDTH = lew_pkg::LINE_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [7:0]                 in_byte,
	input  lew_pkg::cmd_t              cmd,
	output lew_pkg::status_t           st,
	input  logic                       out_stall,
	output logic                       out_valid,
	output logic [2:0]                 action,
	output logic [7:0]                 out_char,
	output logic [lew_pkg::CNT_W-1:0]  rubout_count,
	output logic                       last
);
	import lew_pkg::*;

	localparam int FW = $clog2(LINE_WIDTH + 1);
	localparam int KW = $clog2(LINE_WIDTH + 2);
	localparam int AW = $clog2(LINE_WIDTH);

	logic [7:0]       byte_q;
	logic [FW-1:0]    fill_q, fill_d;
	logic [KW-1:0]    k_q, k_d;
	logic [FW-1:0]    j_q;
	logic [FW-1:0]    wlen_q;
	logic [FW-1:0]    fill_k;
	logic [7:0]       mem_q [LINE_WIDTH];
	logic [7:0]       rdata_q;
	logic [AW-1:0]    raddr, waddr;
	logic [7:0]       wdata;
	logic             out_valid_q;
	action_t          action_q;
	logic [7:0]       char_q, char_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             last_q;
	byte_class_t      byte_cls;

	always_comb begin
		case (cmd.k_op)
			K_HOLD:  k_d = k_q;
			K_FILL:  k_d = KW'(fill_q);
			K_DEC:   k_d = k_q - KW'(1);
			K_INC:   k_d = k_q + KW'(1);
			default: k_d = k_q;
		endcase
	end

	// The read port follows the next pointer, so rdata_q holds the entry below k_q whenever k_q is 1 to LINE_WIDTH.
	always_comb begin
		if (k_d == '0 || k_d > KW'(LINE_WIDTH)) begin
			raddr = '0;
		end else begin
			raddr = AW'(k_d - KW'(1));
		end
	end

	assign fill_k = FW'(KW'(fill_q) - k_q);

	always_comb begin
		case (cmd.fill_op)
			F_HOLD:  fill_d = fill_q;
			F_CLR:   fill_d = '0;
			F_DEC:   fill_d = fill_q - FW'(1);
			F_INC:   fill_d = fill_q + FW'(1);
			F_K:     fill_d = FW'(k_q);
			F_WLEN:  fill_d = wlen_q;
			default: fill_d = fill_q;
		endcase
	end

	assign waddr = cmd.wr_copy ? AW'(j_q) : AW'(fill_q);
	assign wdata = cmd.wr_copy ? rdata_q : byte_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	always_comb begin
		case (cmd.char_sel)
			CHS_ZERO:  char_d = '0;
			CHS_BYTE:  char_d = byte_q;
			CHS_RDATA: char_d = rdata_q;
			default:   char_d = '0;
		endcase
	end

	always_comb begin
		case (cmd.cnt_sel)
			CNT_ZERO:   cnt_d = '0;
			CNT_ONE:    cnt_d = CNT_W'(1);
			CNT_FILL:   cnt_d = CNT_W'(fill_q);
			CNT_FILL_K: cnt_d = CNT_W'(fill_k);
			CNT_WLEN:   cnt_d = CNT_W'(wlen_q);
			default:    cnt_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			k_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			k_q    <= k_d;
			if (cmd.j_clr) begin
				j_q <= '0;
			end else if (cmd.j_inc) begin
				j_q <= j_q + FW'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_byte) begin
			byte_q <= in_byte;
		end
		if (cmd.wlen_load) begin
			wlen_q <= fill_k;
		end
		if (cmd.emit) begin
			action_q <= cmd.act;
			char_q   <= char_d;
			cnt_q    <= cnt_d;
			last_q   <= cmd.last;
		end
	end

	always_comb begin
		unique case (byte_q) inside
			CH_EOT:               byte_cls = CLS_EOT;
			CH_BS, CH_DEL:        byte_cls = CLS_ERASE;
			CH_KILL:              byte_cls = CLS_KILL;
			CH_WERASE:            byte_cls = CLS_WERASE;
			CH_SPACE:             byte_cls = CLS_SPACE;
			[CH_BANG:CH_TILDE]:   byte_cls = CLS_PRINT;
			default:              byte_cls = CLS_OTHER;
		endcase
	end

	assign st.cls       = byte_cls;
	assign st.fill_zero = (fill_q == '0);
	assign st.fill_full = (fill_q >= FW'(LINE_WIDTH));
	assign st.k_zero    = (k_q == '0);
	assign st.fill_eq_k = (KW'(fill_q) == k_q);
	assign st.rd_blank  = (rdata_q == CH_SPACE) || (rdata_q == CH_TAB);
	assign st.j_done    = (j_q == wlen_q);
	assign st.out_free  = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign action       = action_q;
	assign out_char     = char_q;
	assign rubout_count = cnt_q;
	assign last         = last_q;

endmodule
